>>> src/bpe_token_expander_assert.svh
// ----------------------------------------------------------------------------
// bpe_token_expander_assert.svh
// assertion macros used by the token expander walker
// ----------------------------------------------------------------------------
`ifndef BPE_TOKEN_EXPANDER_ASSERT_SVH
`define BPE_TOKEN_EXPANDER_ASSERT_SVH

// condition holds at every edge out of reset
`define BTE_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define BTE_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg
// shared types and constants of the bpe token expander
// ----------------------------------------------------------------------------
package bte_pkg;

	localparam int ID_W   = 9;
	localparam int BYTE_W = 8;
	localparam int ERR_W  = 2;
	localparam int PAIR_W = 2 * ID_W;

	localparam int MERGE_ENTRIES_DEF = 32;
	localparam int MAX_EXPANSION_DEF = 64;
	localparam int STACK_DEPTH_DEF   = 32;

	localparam logic [ID_W-1:0] VOCAB_RESET = 9'd256;

	localparam logic KIND_DECODE = 1'b0;
	localparam logic KIND_WRITE  = 1'b1;

	localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OOV  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_LONG = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   tok_id;
		logic [ID_W-1:0]   left_child;
		logic [ID_W-1:0]   right_child;
	} bte_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic              last;
		logic [ERR_W-1:0]  error_code;
	} bte_beat_t;

endpackage

>>> src/bpe_token_expander.sv
// ----------------------------------------------------------------------------
// bpe_token_expander
// expands byte-pair-encoding token ids into raw bytes via a merge store
// ----------------------------------------------------------------------------
// channel   dir  tdata / data           tuser       tlast
// s_axis    in   tok_id,left,right      kind        -
// m_axis    out  byte_out               error_code  last
// cfg       in   vocabulary size        -           -
//
// a merge write beat goes straight into the merge store; a decode walks its
// pair tree twice, first to check for faults, then to emit; each leaf is one
// step, each merged node a merge store read, then a push, and each stack pop one
// reset clears the walk state and sets the vocabulary size to 256; the merge
// store holds no reset value and the pending stack is emptied by its count alone
// a stalled output beat holds the walk; the input takes no beat mid walk
// ----------------------------------------------------------------------------
module bpe_token_expander
	import bte_pkg::*;
#(
	parameter int MERGE_ENTRIES = MERGE_ENTRIES_DEF,
	parameter int MAX_EXPANSION = MAX_EXPANSION_DEF,
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [31:0]      s_axis_tdata,  // tok_id, left_child, right_child
	input  logic             s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // byte_out
	output logic [1:0]       m_axis_tuser,  // error_code
	output logic             m_axis_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ID_W-1:0]  cfg_data
);

	localparam int MA_W = (MERGE_ENTRIES > 1) ? $clog2(MERGE_ENTRIES) : 1;

	logic [ID_W-1:0]   vocab_q;
	bte_item_t         item;
	logic              mwr_en;
	logic [MA_W-1:0]   mwr_addr;
	logic [PAIR_W-1:0] mwr_data;
	logic              mrd_en;
	logic [MA_W-1:0]   mrd_addr;
	logic [PAIR_W-1:0] mrd_data;
	logic              out_free;
	logic              out_load;
	bte_beat_t         beat;
	logic              out_valid_q;
	bte_beat_t         out_q;

	assign item.kind        = s_axis_tuser;
	assign item.tok_id      = s_axis_tdata[ID_W-1:0];
	assign item.left_child  = s_axis_tdata[2*ID_W-1:ID_W];
	assign item.right_child = s_axis_tdata[3*ID_W-1:2*ID_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= VOCAB_RESET;
		end else if (cfg_valid) begin
			vocab_q <= cfg_data;
		end
	end

	bte_merge_mem #(
		.MERGE_ENTRIES (MERGE_ENTRIES),
		.MA_W          (MA_W)
	) u_merge (
		.clk     (clk),
		.wr_en   (mwr_en),
		.wr_addr (mwr_addr),
		.wr_data (mwr_data),
		.rd_en   (mrd_en),
		.rd_addr (mrd_addr),
		.rd_data (mrd_data)
	);

	bte_walker #(
		.MERGE_ENTRIES (MERGE_ENTRIES),
		.MAX_EXPANSION (MAX_EXPANSION),
		.STACK_DEPTH   (STACK_DEPTH),
		.MA_W          (MA_W)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.vocab    (vocab_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.mwr_en   (mwr_en),
		.mwr_addr (mwr_addr),
		.mwr_data (mwr_data),
		.mrd_en   (mrd_en),
		.mrd_addr (mrd_addr),
		.mrd_data (mrd_data),
		.out_free (out_free),
		.out_load (out_load),
		.out_beat (beat)
	);

	// output beat register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= beat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.byte_out;
	assign m_axis_tuser  = out_q.error_code;
	assign m_axis_tlast  = out_q.last;

endmodule

>>> src/bte_merge_mem.sv
// ----------------------------------------------------------------------------
// bte_merge_mem
// merge store: one write port, one registered read port
// ----------------------------------------------------------------------------
module bte_merge_mem
	import bte_pkg::*;
#(
	parameter int MERGE_ENTRIES = MERGE_ENTRIES_DEF,
	parameter int MA_W          = (MERGE_ENTRIES > 1) ? $clog2(MERGE_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [MA_W-1:0]   wr_addr,
	input  logic [PAIR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [MA_W-1:0]   rd_addr,
	output logic [PAIR_W-1:0] rd_data
);

	logic [PAIR_W-1:0] mem [MERGE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/bte_walker.sv
// ----------------------------------------------------------------------------
// bte_walker
// pair tree walker: check pass, then emit pass, with the pending stack
// ----------------------------------------------------------------------------
module bte_walker
	import bte_pkg::*;
#(
	parameter int MERGE_ENTRIES = MERGE_ENTRIES_DEF,
	parameter int MAX_EXPANSION = MAX_EXPANSION_DEF,
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int MA_W          = (MERGE_ENTRIES > 1) ? $clog2(MERGE_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   vocab,
	input  logic              in_valid,
	output logic              in_ready,
	input  bte_item_t         in_item,
	output logic              mwr_en,
	output logic [MA_W-1:0]   mwr_addr,
	output logic [PAIR_W-1:0] mwr_data,
	output logic              mrd_en,
	output logic [MA_W-1:0]   mrd_addr,
	input  logic [PAIR_W-1:0] mrd_data,
	input  logic              out_free,
	output logic              out_load,
	output bte_beat_t         out_beat
);

	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int NW   = $clog2(MAX_EXPANSION + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;
	localparam logic [1:0] ST_POP   = 2'd3;

	logic [1:0]       state_q;
	logic             pass_q;
	logic [ID_W-1:0]  cur_q;
	logic [ID_W-1:0]  root_q;
	logic [CW-1:0]    cnt_q;
	logic [NW-1:0]    nb_q;

	logic [ID_W-1:0]  stk [STACK_DEPTH];
	logic [ID_W-1:0]  stk_rd_q;

	logic             is_byte;
	logic             in_store;
	logic             oov;
	logic             too_long;
	logic             full;
	logic             fault;
	logic             leaf;
	logic             go_merge;
	logic             stall;
	logic             pop;
	logic [ERR_W-1:0] err;
	logic [SA_W-1:0]  pop_addr;
	logic [CW-1:0]    cnt_dec;

	assign in_ready = (state_q == ST_IDLE);
	assign is_byte  = !cur_q[ID_W-1];
	assign in_store = {1'b0, cur_q[BYTE_W-1:0]} < ID_W'(MERGE_ENTRIES);
	assign oov      = (cur_q >= vocab) || !in_store;
	assign too_long = nb_q >= NW'(MAX_EXPANSION);
	assign full     = cnt_q == CW'(STACK_DEPTH);
	assign cnt_dec  = cnt_q - 1'b1;
	assign pop_addr = cnt_dec[SA_W-1:0];

	always_comb begin
		fault    = 1'b0;
		leaf     = 1'b0;
		go_merge = 1'b0;
		err      = ERR_OK;
		if (state_q == ST_EVAL) begin
			if (is_byte) begin
				if (too_long) begin
					fault = 1'b1;
					err   = ERR_LONG;
				end else begin
					leaf = 1'b1;
				end
			end else if (oov) begin
				fault = 1'b1;
				err   = ERR_OOV;
			end else if (full) begin
				fault = 1'b1;
				err   = ERR_OVF;
			end else begin
				go_merge = 1'b1;
			end
		end
	end

	assign stall    = (fault || (leaf && pass_q)) && !out_free;
	assign out_load = !stall && (fault || (leaf && pass_q));
	assign pop      = leaf && !stall && (cnt_q != '0);

	assign out_beat.byte_out   = fault ? '0 : cur_q[BYTE_W-1:0];
	assign out_beat.last       = fault || (cnt_q == '0);
	assign out_beat.error_code = err;

	assign mrd_en   = go_merge;
	assign mrd_addr = cur_q[MA_W-1:0];

	assign mwr_en   = in_valid && in_ready && (in_item.kind == KIND_WRITE)
		&& in_item.tok_id[ID_W-1]
		&& ({1'b0, in_item.tok_id[BYTE_W-1:0]} < ID_W'(MERGE_ENTRIES));
	assign mwr_addr = in_item.tok_id[MA_W-1:0];
	assign mwr_data = {in_item.left_child, in_item.right_child};

	// pending right children
	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE) begin
			stk[cnt_q[SA_W-1:0]] <= mrd_data[ID_W-1:0];
		end
		if (pop) begin
			stk_rd_q <= stk[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
			nb_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && (in_item.kind == KIND_DECODE)) begin
						cur_q   <= in_item.tok_id;
						root_q  <= in_item.tok_id;
						cnt_q   <= '0;
						nb_q    <= '0;
						pass_q  <= 1'b0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (fault && !stall) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else if (leaf && !stall) begin
						nb_q <= nb_q + 1'b1;
						if (cnt_q == '0) begin
							if (pass_q) begin
								state_q <= ST_IDLE;
							end else begin
								// check pass clean, walk again and emit
								pass_q <= 1'b1;
								cur_q  <= root_q;
								nb_q   <= '0;
							end
						end else begin
							cnt_q   <= cnt_dec;
							state_q <= ST_POP;
						end
					end else if (go_merge) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					cnt_q   <= cnt_q + 1'b1;
					cur_q   <= mrd_data[PAIR_W-1:ID_W];
					state_q <= ST_EVAL;
				end
				ST_POP: begin
					cur_q   <= stk_rd_q;
					state_q <= ST_EVAL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "bpe_token_expander_assert.svh"

	`BTE_ASSERT_IMPLIES(a_push_room, state_q == ST_MERGE, cnt_q < CW'(STACK_DEPTH), "push on full stack")
	`BTE_ASSERT_HOLDS(a_nb_bound, nb_q <= NW'(MAX_EXPANSION), "byte count past cap")
	`BTE_ASSERT_IMPLIES(a_emit_pass, out_load && !fault, pass_q, "byte emitted during check pass")
	`BTE_ASSERT_NEXT(a_merge_eval, state_q == ST_MERGE, state_q == ST_EVAL, "merge step not followed by eval")

endmodule
